// ===== sv/mtss_pkg.sv =====
// Shared constants, codes and types of the multi-term stream search block.
package mtss_pkg;

  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 4;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 8;
  localparam int MASK_W   = 16;

  localparam int NUM_TERMS_DEF = 16;
  localparam int MAX_LEN_DEF   = 16;

  localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LENGTH = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_START  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_BYTE   = 2'd3;

  // One request as held in the input register.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  term_index;
    logic [POS_W-1:0]    char_pos;
    logic [VALUE_W-1:0]  value;
  } req_t;

  // Table write control handed to one term unit.
  typedef struct packed {
    logic               load_byte;
    logic               load_len;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } term_wr_t;

endpackage

// ===== sv/mtss_if.sv =====
// Request and result channel interfaces of the multi-term stream search block.
interface mtss_req_if;
  logic                          valid;
  logic                          ready;
  logic [mtss_pkg::OPCODE_W-1:0] opcode;
  logic [mtss_pkg::INDEX_W-1:0]  term_index;
  logic [mtss_pkg::POS_W-1:0]    char_pos;
  logic [mtss_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output opcode, output term_index, output char_pos,
                  output value, input ready);
  modport sink (input valid, input opcode, input term_index, input char_pos,
                input value, output ready);
endinterface

interface mtss_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [mtss_pkg::MASK_W-1:0] found_mask;
  logic [mtss_pkg::MASK_W-1:0] new_mask;

  modport source (output valid, output found_mask, output new_mask, input ready);
  modport sink (input valid, input found_mask, input new_mask, output ready);
endinterface

// ===== sv/mtss_term.sv =====
// One search term: its byte row, its length and its compare against the history.
module mtss_term #(
  parameter int MAX_LEN = mtss_pkg::MAX_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mtss_pkg::term_wr_t   wr,
  input  logic [MAX_LEN*8-1:0] hist,
  input  logic [$clog2(MAX_LEN+1)-1:0] seen,
  output logic                 hit
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [7:0]    bytes_r [MAX_LEN];
  logic [LW-1:0] len_r;
  logic [IW-1:0] sel;
  logic          ok;

  // Term bytes have no reset; the user, not the unit, loads each compared byte.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_LEN; k++) begin
      if (wr.load_byte && (32'(wr.pos) == k)) begin
        bytes_r[k] <= wr.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (wr.load_len && (32'(wr.value) <= MAX_LEN)) begin
      len_r <= LW'(wr.value);
    end
  end

  // Byte k of the term lines up with history entry len-1-k (entry 0 is newest).
  always_comb begin
    ok  = 1'b1;
    sel = '0;
    for (int k = 0; k < MAX_LEN; k++) begin
      if (LW'(k) < len_r) begin
        sel = IW'(len_r - LW'(k) - LW'(1));
        ok  = ok & (bytes_r[k] == hist[32'(sel)*8 +: 8]);
      end
    end
    hit = ok && (len_r != '0) && (len_r <= seen);
  end

endmodule

// ===== sv/multi_term_stream_search.sv =====
// Top level of the multi-term stream search block.
//
// The block holds a table of search terms, each 1 to MAX_LEN bytes long, and
// watches a byte stream for them. Every request yields exactly one result.
// Load requests write one term byte, length requests set a term's length
// (zero marks the term unused, a length above MAX_LEN is ignored), a start
// request begins a new stream, and a stream byte is shifted into a history
// of the last MAX_LEN bytes. After a stream byte, every term is compared in
// parallel against the tail of the history; the result carries the mask of
// all terms found so far in this stream and the mask of those found for the
// first time on this byte. Other requests return the current found mask and
// an empty new mask. Only terms 0 to 15 are addressable and reported. A term
// matches only once the stream holds at least as many bytes as its length,
// and table changes during a stream apply from the next stream byte on.
// The block takes one request per clock cycle while results drain; when the
// result register waits on the receiver, the input register holds too, and
// with both full the block drops its input ready. A request sits in the
// input register and passes through the term compare logic into the result
// register, with the per-term compare of all table bytes against the
// history done in that single pass. The result register stalls only the
// input register behind it, so a new request is accepted while a finished
// result waits. Term bytes come up undefined after reset; a term must have
// every byte loaded that its length covers before a stream uses it.
module multi_term_stream_search #(
  parameter int NUM_TERMS = mtss_pkg::NUM_TERMS_DEF,
  parameter int MAX_LEN   = mtss_pkg::MAX_LEN_DEF
) (
  input logic       clk,
  input logic       rst_n,
  mtss_req_if.sink  in_req,
  mtss_rsp_if.source out_rsp
);

  localparam int MW = mtss_pkg::MASK_W;
  // Only terms reachable through the index field are built.
  localparam int NT = (NUM_TERMS < MW) ? NUM_TERMS : MW;
  localparam int LW = $clog2(MAX_LEN + 1);

  // Input register.
  logic           req_valid_r;
  mtss_pkg::req_t req_r;

  // Stream state.
  logic [7:0]    hist_r [MAX_LEN];
  logic [7:0]    hist_nxt [MAX_LEN];
  logic [LW-1:0] seen_r;
  logic [LW-1:0] seen_nxt;
  logic [NT-1:0] found_r;
  logic [NT-1:0] found_nxt;

  // Result register.
  logic          out_valid_r;
  logic [MW-1:0] out_found_r;
  logic [MW-1:0] out_new_r;

  logic                 advance;
  logic                 is_byte;
  logic [MAX_LEN*8-1:0] hist_flat;
  logic [NT-1:0]        hits;
  logic [NT-1:0]        fresh;

  // The input register moves on when the result register is empty or drains.
  assign advance      = req_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !req_valid_r || advance;
  assign is_byte      = (req_r.opcode == mtss_pkg::OP_BYTE);

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.found_mask = out_found_r;
  assign out_rsp.new_mask   = out_new_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      req_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      req_r.opcode     <= in_req.opcode;
      req_r.term_index <= in_req.term_index;
      req_r.char_pos   <= in_req.char_pos;
      req_r.value      <= in_req.value;
    end
  end

  // History as it stands after the current stream byte. Entries beyond the
  // byte count are never compared, so a new stream needs no clearing of it.
  always_comb begin
    hist_nxt[0] = req_r.value;
    for (int k = 1; k < MAX_LEN; k++) begin
      hist_nxt[k] = hist_r[k-1];
    end
    for (int k = 0; k < MAX_LEN; k++) begin
      hist_flat[k*8 +: 8] = hist_nxt[k];
    end
    seen_nxt = (seen_r == LW'(MAX_LEN)) ? seen_r : (seen_r + LW'(1));
  end

  // One compare unit per term, each with its own table row.
  for (genvar t = 0; t < NT; t++) begin : g_term
    mtss_pkg::term_wr_t wr;

    always_comb begin
      wr.load_byte = advance && (req_r.opcode == mtss_pkg::OP_LOAD)
                     && (32'(req_r.term_index) == t);
      wr.load_len  = advance && (req_r.opcode == mtss_pkg::OP_LENGTH)
                     && (32'(req_r.term_index) == t);
      wr.pos       = req_r.char_pos;
      wr.value     = req_r.value;
    end

    mtss_term #(
      .MAX_LEN (MAX_LEN)
    ) u_term (
      .clk   (clk),
      .rst_n (rst_n),
      .wr    (wr),
      .hist  (hist_flat),
      .seen  (seen_nxt),
      .hit   (hits[t])
    );
  end

  always_comb begin
    fresh     = is_byte ? (hits & ~found_r) : '0;
    found_nxt = found_r;
    case (req_r.opcode)
      mtss_pkg::OP_START: found_nxt = '0;
      mtss_pkg::OP_BYTE:  found_nxt = found_r | fresh;
      default:            found_nxt = found_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      found_r <= '0;
    end else if (advance) begin
      found_r <= found_nxt;
      if (req_r.opcode == mtss_pkg::OP_START) begin
        seen_r <= '0;
      end else if (is_byte) begin
        seen_r <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_byte) begin
      for (int k = 0; k < MAX_LEN; k++) begin
        hist_r[k] <= hist_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_found_r <= MW'(found_nxt);
      out_new_r   <= MW'(fresh);
    end
  end

`ifndef SYNTHESIS
  // A term reported as new must also be reported as found.
  a_new_in_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_new_r & ~out_found_r) == '0))
    else $error("new mask holds a term that is not in the found mask");

  // Found marks only grow within a stream.
  a_found_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (req_r.opcode != mtss_pkg::OP_START))
    |=> ((found_r & $past(found_r)) == $past(found_r)))
    else $error("found mark lost without a stream start");

  // A stream start clears the byte count and the found marks.
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (req_r.opcode == mtss_pkg::OP_START))
    |=> ((found_r == '0) && (seen_r == '0)))
    else $error("stream start did not clear the stream state");

  // The byte count saturates at the history depth.
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= LW'(MAX_LEN))
    else $error("byte count beyond history depth");
`endif

endmodule

// ===== tb/multi_term_stream_search_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the multi-term stream search block.
module multi_term_stream_search_test;

  localparam int OPCODE_W = mtss_pkg::OPCODE_W;
  localparam int INDEX_W  = mtss_pkg::INDEX_W;
  localparam int POS_W    = mtss_pkg::POS_W;
  localparam int VALUE_W  = mtss_pkg::VALUE_W;
  localparam int MASK_W   = mtss_pkg::MASK_W;

  localparam logic [OPCODE_W-1:0] OP_LOAD   = mtss_pkg::OP_LOAD;
  localparam logic [OPCODE_W-1:0] OP_LENGTH = mtss_pkg::OP_LENGTH;
  localparam logic [OPCODE_W-1:0] OP_START  = mtss_pkg::OP_START;
  localparam logic [OPCODE_W-1:0] OP_BYTE   = mtss_pkg::OP_BYTE;

  localparam int NUM_TERMS       = mtss_pkg::NUM_TERMS_DEF;
  localparam int MAX_LEN         = mtss_pkg::MAX_LEN_DEF;
  localparam int RANDOM_ITEMS    = 600;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_LIMIT     = 20000;

  // One result as the block reports it: cumulative mask and first-hit mask.
  typedef struct packed {
    logic [MASK_W-1:0] found;
    logic [MASK_W-1:0] fresh;
  } masks_t;

  // One row of the directed script. Rows with typed set carry a result that
  // is obvious by inspection; the others are checked against the predictor.
  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [INDEX_W-1:0]  idx;
    logic [POS_W-1:0]    pos;
    logic [VALUE_W-1:0]  val;
    bit                  typed;
    masks_t              want;
  } script_row_t;

  logic clk;
  logic rst_n;

  mtss_req_if req_bus ();
  mtss_rsp_if rsp_bus ();

  multi_term_stream_search uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_bus),
    .out_rsp(rsp_bus)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predictor state: the term table, the stream history and the found marks.
  // The history is newest first, so history[0] is the last stream byte.
  logic [VALUE_W-1:0] term_tbl [NUM_TERMS][MAX_LEN];
  int                 term_len [NUM_TERMS];
  logic [VALUE_W-1:0] history [MAX_LEN];
  int                 hist_fill;
  logic [MASK_W-1:0]  found_marks;

  // Stimulus bookkeeping: which term bytes have been written. A length is
  // only set once every byte it covers has been loaded, so the block never
  // compares a table byte that holds no defined value.
  bit byte_loaded [NUM_TERMS][MAX_LEN];

  masks_t pending_masks [$];
  int     fail_count     = 0;
  int     items_sent     = 0;
  int     idle_pct       = 0;
  int     stall_pct      = 0;
  bit     pressure_armed = 1'b0;

  script_row_t script [19];

  // Applies one accepted request to the predictor state and returns the
  // result the block must produce for it.
  function automatic masks_t search_step(input logic [OPCODE_W-1:0] op,
                                         input logic [INDEX_W-1:0]  idx,
                                         input logic [POS_W-1:0]    pos,
                                         input logic [VALUE_W-1:0]  val);
    masks_t            res;
    logic [MASK_W-1:0] fresh;
    bit                hit;
    int                len;
    fresh = '0;
    case (op)
      OP_LOAD: begin
        term_tbl[idx][pos] = val;
      end
      OP_LENGTH: begin
        // A length above MAX_LEN leaves the old length in place.
        if (int'(val) <= MAX_LEN) term_len[idx] = int'(val);
      end
      OP_START: begin
        foreach (history[i]) history[i] = '0;
        hist_fill   = 0;
        found_marks = '0;
      end
      default: begin
        for (int i = MAX_LEN - 1; i > 0; i--) history[i] = history[i-1];
        history[0] = val;
        if (hist_fill < MAX_LEN) hist_fill++;
        // A term hits when its last byte lines up with the newest byte. Empty
        // terms and terms longer than the stream so far never hit, and a term
        // already found in this stream is not reported again.
        for (int t = 0; t < NUM_TERMS; t++) begin
          len = term_len[t];
          hit = !found_marks[t] && len != 0 && len <= hist_fill;
          for (int k = 0; k < len; k++) begin
            if (term_tbl[t][k] != history[len-1-k]) hit = 1'b0;
          end
          fresh[t] = hit;
        end
        found_marks = found_marks | fresh;
      end
    endcase
    res.found = found_marks;
    res.fresh = fresh;
    return res;
  endfunction

  // Offers one request, with random idle cycles ahead of it, and waits until
  // the block takes it. Valid is never lowered after acceptance here: the
  // next call either raises it again or idles, so each signal gets a single
  // nonblocking assignment per time step.
  task automatic send_req(input logic [OPCODE_W-1:0] op,
                          input logic [INDEX_W-1:0]  idx,
                          input logic [POS_W-1:0]    pos,
                          input logic [VALUE_W-1:0]  val,
                          input bit                  typed = 1'b0,
                          input masks_t              want  = '0);
    masks_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.opcode     <= op;
    req_bus.term_index <= idx;
    req_bus.char_pos   <= pos;
    req_bus.value      <= val;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predicted = search_step(op, idx, pos, val);
    if (op == OP_LOAD) byte_loaded[idx][pos] = 1'b1;
    if (typed) predicted = want;
    pending_masks = {pending_masks, predicted};
    items_sent++;
  endtask

  // Stream and term bytes mostly come from a four-letter alphabet so that
  // random streams hit random terms; the rest spans the whole byte range.
  function automatic logic [VALUE_W-1:0] pick_symbol();
    if ($urandom_range(0, 99) < 80) return VALUE_W'(8'h41 + $urandom_range(0, 3));
    return VALUE_W'($urandom);
  endfunction

  // Short terms dominate; the full MAX_LEN length still turns up regularly.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 3);
    if (r < 85) return $urandom_range(4, 8);
    if (r < 95) return $urandom_range(9, MAX_LEN - 1);
    return MAX_LEN;
  endfunction

  // Loads a term with new content and then sets its length. Bytes already
  // loaded are rewritten only some of the time, so old content survives too.
  task automatic program_term(input int t, input int len);
    for (int p = 0; p < len; p++) begin
      if (!byte_loaded[t][p] || $urandom_range(0, 1) == 1) begin
        send_req(OP_LOAD, INDEX_W'(t), POS_W'(p), pick_symbol());
      end
    end
    send_req(OP_LENGTH, INDEX_W'(t), POS_W'($urandom), VALUE_W'(len));
  endtask

  // Result side. Ready stalls at the rate the current phase asks for. Once
  // the stimulus arms it, the receiver also holds off for a long stretch so
  // that both pipeline stages fill and the block drops its input ready.
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left     = 0;
    hold_done     = 1'b0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (!rst_n) begin
        rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    masks_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_masks.size() == 0) begin
        $display("%0t: result with nothing expected: found_mask %h new_mask %h",
                 $time, rsp_bus.found_mask, rsp_bus.new_mask);
        fail_count++;
      end else begin
        want = pending_masks.pop_front();
        if (rsp_bus.found_mask !== want.found) begin
          $display("%0t: found_mask expected %h actual %h",
                   $time, want.found, rsp_bus.found_mask);
          fail_count++;
        end
        if (rsp_bus.new_mask !== want.fresh) begin
          $display("%0t: new_mask expected %h actual %h",
                   $time, want.fresh, rsp_bus.new_mask);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int n_bytes;
    int r;
    int t;
    int len;
    int cycles;
    logic [VALUE_W-1:0] word [MAX_LEN];

    foreach (term_len[i]) term_len[i] = 0;
    foreach (history[i]) history[i] = '0;
    foreach (byte_loaded[i, j]) byte_loaded[i][j] = 1'b0;
    hist_fill   = 0;
    found_marks = '0;

    rst_n              = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.opcode     = OP_LOAD;
    req_bus.term_index = '0;
    req_bus.char_pos   = '0;
    req_bus.value      = '0;

    // Directed script. It opens on a stream byte with an empty table, tries
    // lengths above MAX_LEN, builds a two-byte term from the extreme byte
    // values and shows it cannot hit before the stream is long enough. It
    // then adds a one-byte term in the middle of a stream (marks survive and
    // the new term applies from the next byte), repeats a found term, empties
    // a term with length zero and restarts the stream.
    script = '{
      '{OP_BYTE,   4'd0,  4'd0,  8'h00, 1'b1, '{16'h0000, 16'h0000}},
      '{OP_LENGTH, 4'd0,  4'd0,  8'd17, 1'b1, '{16'h0000, 16'h0000}},
      '{OP_LENGTH, 4'd15, 4'd15, 8'hFF, 1'b1, '{16'h0000, 16'h0000}},
      '{OP_LOAD,   4'd0,  4'd0,  8'h00, 1'b1, '{16'h0000, 16'h0000}},
      '{OP_LOAD,   4'd0,  4'd1,  8'hFF, 1'b1, '{16'h0000, 16'h0000}},
      '{OP_LENGTH, 4'd0,  4'd0,  8'd2,  1'b1, '{16'h0000, 16'h0000}},
      '{OP_START,  4'd15, 4'd15, 8'hFF, 1'b1, '{16'h0000, 16'h0000}},
      '{OP_BYTE,   4'd0,  4'd0,  8'h00, 1'b1, '{16'h0000, 16'h0000}},
      '{OP_BYTE,   4'd15, 4'd15, 8'hFF, 1'b0, '{16'h0000, 16'h0000}},
      '{OP_BYTE,   4'd0,  4'd0,  8'h00, 1'b0, '{16'h0000, 16'h0000}},
      '{OP_LOAD,   4'd15, 4'd15, 8'h5A, 1'b0, '{16'h0000, 16'h0000}},
      '{OP_LOAD,   4'd15, 4'd0,  8'hFF, 1'b0, '{16'h0000, 16'h0000}},
      '{OP_LENGTH, 4'd15, 4'd0,  8'd1,  1'b0, '{16'h0000, 16'h0000}},
      '{OP_BYTE,   4'd0,  4'd0,  8'hFF, 1'b0, '{16'h0000, 16'h0000}},
      '{OP_LENGTH, 4'd0,  4'd0,  8'd0,  1'b0, '{16'h0000, 16'h0000}},
      '{OP_START,  4'd0,  4'd0,  8'h00, 1'b1, '{16'h0000, 16'h0000}},
      '{OP_BYTE,   4'd0,  4'd0,  8'h00, 1'b0, '{16'h0000, 16'h0000}},
      '{OP_BYTE,   4'd0,  4'd0,  8'hFF, 1'b0, '{16'h0000, 16'h0000}},
      '{OP_LENGTH, 4'd15, 4'd0,  8'd0,  1'b0, '{16'h0000, 16'h0000}}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      send_req(script[i].op, script[i].idx, script[i].pos, script[i].val,
               script[i].typed, script[i].want);
    end

    // Random part, in episodes: reprogram a few terms, usually start a new
    // stream, then send a stream in which whole terms are often embedded.
    // Some items are noise: oversized or zero lengths, stray loads and table
    // rewrites in the middle of a stream. The idling phase changes every
    // fifty requests, and the first quiet phase arms the long hold-off.
    while (items_sent < $size(script) + RANDOM_ITEMS) begin
      case ((items_sent / 50) % 4)
        0: begin
          idle_pct       = 0;
          stall_pct      = 0;
          pressure_armed = 1'b1;
        end
        1: begin
          idle_pct  = 66;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 66;
        end
        default: begin
          idle_pct  = 7;
          stall_pct = 7;
        end
      endcase

      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 3)) program_term($urandom_range(0, NUM_TERMS - 1), pick_len());
      end
      if ($urandom_range(0, 9) < 8) begin
        send_req(OP_START, INDEX_W'($urandom), POS_W'($urandom), VALUE_W'($urandom));
      end

      n_bytes = $urandom_range(4, 40);
      repeat (n_bytes) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          // Embed a whole term in the stream. The bytes are copied first so
          // that the copy does not depend on when the predictor runs.
          t   = $urandom_range(0, NUM_TERMS - 1);
          len = term_len[t];
          for (int k = 0; k < len; k++) word[k] = term_tbl[t][k];
          for (int k = 0; k < len; k++) begin
            send_req(OP_BYTE, INDEX_W'($urandom), POS_W'($urandom), word[k]);
          end
        end else if (r < 28) begin
          case ($urandom_range(0, 3))
            0: send_req(OP_LENGTH, INDEX_W'($urandom), POS_W'($urandom),
                        VALUE_W'($urandom_range(MAX_LEN + 1, 255)));
            1: send_req(OP_LOAD, INDEX_W'($urandom), POS_W'($urandom), VALUE_W'($urandom));
            2: send_req(OP_LENGTH, INDEX_W'($urandom), POS_W'($urandom), '0);
            default: program_term($urandom_range(0, NUM_TERMS - 1), pick_len());
          endcase
        end else begin
          send_req(OP_BYTE, INDEX_W'($urandom), POS_W'($urandom), pick_symbol());
        end
      end
    end

    req_bus.valid <= 1'b0;

    // Let every outstanding result drain, then keep watching the bus for
    // anything the block should not have produced.
    cycles = 0;
    while (pending_masks.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    repeat (10) @(posedge clk);

    if (pending_masks.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_masks.size());
    end
    if (fail_count == 0 && pending_masks.size() == 0) begin
      $display("multi_term_stream_search test passed");
    end else begin
      $display("multi_term_stream_search test failed");
    end
    $finish;
  end

  // A correct run ends far sooner; this only catches a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("multi_term_stream_search test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mtss_pkg.sv
sv/mtss_if.sv
sv/mtss_term.sv
sv/multi_term_stream_search.sv
tb/multi_term_stream_search_test.sv
